[hdl/llmf_pkg.sv]
// Package for the line literal match finder: item types, register indexes,
// widths and the ASCII case-fold function. No dependencies.
`default_nettype none

package llmf_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned LINE_W     = 24;
  localparam int unsigned COLOUT_W   = 16;
  localparam int unsigned HITS_W     = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned PAT_BYTES  = 16;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [BYTE_W-1:0] UPPER_A      = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z      = 8'h5A;
  localparam logic [BYTE_W-1:0] FOLD_OFFSET  = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 8'd0,
    REG_PATTERN_HIGH   = 8'd1,
    REG_PATTERN_LENGTH = 8'd2,
    REG_CASE_SENSITIVE = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              new_file;
  } in_item_t;

  typedef struct packed {
    logic [LINE_W-1:0]   line_number;
    logic [COLOUT_W-1:0] match_column;
    logic                first_in_line;
    logic [HITS_W-1:0]   total_hits;
  } out_item_t;

  // Per-cycle control shared by every window cell.
  typedef struct packed {
    logic shift;
    logic fold;
  } cell_ctrl_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                  input logic fold);
    logic [BYTE_W-1:0] r;
    r = b;
    if (fold && b >= UPPER_A && b <= UPPER_Z) begin
      r = b + FOLD_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/llmf_cell.sv]
// One window cell: holds one recent text byte, hands it to the next cell on
// a shift and compares the incoming byte with its pattern byte. Uses llmf_pkg.
`default_nettype none

module llmf_cell (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire llmf_pkg::cell_ctrl_t          ctrl_i,
  input  wire logic [llmf_pkg::BYTE_W-1:0]   data_i,
  input  wire logic [llmf_pkg::BYTE_W-1:0]   pat_byte_i,
  input  wire logic                          active_i,
  output logic [llmf_pkg::BYTE_W-1:0]        data_o,
  output logic                               hit_o
);

  logic [llmf_pkg::BYTE_W-1:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (ctrl_i.shift) begin
      byte_q <= data_i;
    end
  end

  assign data_o = byte_q;

  // Compare the value this cell takes on the shift; idle cells always agree.
  assign hit_o = !active_i ||
                 (llmf_pkg::fold_byte(data_i, ctrl_i.fold) ==
                  llmf_pkg::fold_byte(pat_byte_i, ctrl_i.fold));

endmodule

`default_nettype wire

[hdl/llmf_out_fifo.sv]
// Two-entry result buffer between the match logic and the output channel.
// Uses llmf_pkg.
`default_nettype none

module llmf_out_fifo (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire logic                  push_i,
  input  wire llmf_pkg::out_item_t   item_i,
  output logic                       ready_o,
  output logic                       valid_o,
  input  wire logic                  pop_ready_i,
  output llmf_pkg::out_item_t        item_o
);

  llmf_pkg::out_item_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic [1:0] count_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign ready_o = (count_q != 2'd2);
  assign pop     = valid_o && pop_ready_i;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

[hdl/line_literal_match_finder.sv]
// Line literal match finder, top level: window cell chain, line/column/hit
// counters, configuration registers and result buffer. Uses llmf_pkg,
// llmf_cell and llmf_out_fifo.
// Throughput: one text byte per cycle while in_ready_o is high. A match is
// pushed into the result buffer as its byte is accepted. The two-entry result
// buffer sets when input stalls: in_ready_o drops only while both entries wait.
// Reset: window bytes zero, line 1, column, resume column, hit total and
// per-line flag zero; pattern zero, length 1, case folding on.
`default_nettype none

module line_literal_match_finder #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire llmf_pkg::in_item_t              in_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output llmf_pkg::out_item_t                  out_item_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [llmf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [llmf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned LEN_W  = llmf_pkg::LEN_W;
  localparam int unsigned BYTE_W = llmf_pkg::BYTE_W;

  // ---------------------------------------------------------------------
  // Configuration registers. Writes land at once; the port never stalls.
  // ---------------------------------------------------------------------
  logic [llmf_pkg::CFG_DATA_W-1:0] pat_low_q;
  logic [llmf_pkg::CFG_DATA_W-1:0] pat_high_q;
  logic [LEN_W-1:0]                len_q;
  logic                            case_sens_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q   <= '0;
      pat_high_q  <= '0;
      len_q       <= LEN_W'(1);
      case_sens_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        llmf_pkg::REG_PATTERN_LOW:    pat_low_q   <= cfg_data_i;
        llmf_pkg::REG_PATTERN_HIGH:   pat_high_q  <= cfg_data_i;
        llmf_pkg::REG_PATTERN_LENGTH: len_q       <= cfg_data_i[LEN_W-1:0];
        llmf_pkg::REG_CASE_SENSITIVE: case_sens_q <= cfg_data_i[0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  logic [llmf_pkg::PAT_BYTES*BYTE_W-1:0] pat_all;
  assign pat_all = {pat_high_q, pat_low_q};

  // ---------------------------------------------------------------------
  // Input handshake and per-line state as seen by this byte. A new-file
  // flag restarts the line state before the byte is handled.
  // ---------------------------------------------------------------------
  logic in_fire;
  logic is_newline;
  logic fifo_ready;

  assign in_ready_o = fifo_ready;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_newline = (in_item_i.text_byte == llmf_pkg::NEWLINE_BYTE);

  logic [COLUMN_BITS-1:0]      col_q, col_d;
  logic [COLUMN_BITS-1:0]      resume_q, resume_d;
  logic [llmf_pkg::LINE_W-1:0] line_q, line_d;
  logic [llmf_pkg::HITS_W-1:0] hits_q, hits_d;
  logic                        has_hit_q, has_hit_d;

  logic [COLUMN_BITS-1:0]      eff_col;
  logic [COLUMN_BITS-1:0]      eff_resume;
  logic [llmf_pkg::LINE_W-1:0] eff_line;
  logic                        eff_has_hit;

  assign eff_col     = in_item_i.new_file ? '0 : col_q;
  assign eff_resume  = in_item_i.new_file ? '0 : resume_q;
  assign eff_line    = in_item_i.new_file ? llmf_pkg::LINE_W'(1) : line_q;
  assign eff_has_hit = in_item_i.new_file ? 1'b0 : has_hit_q;

  // ---------------------------------------------------------------------
  // Window cell chain. Cell i takes the i-th newest byte (the incoming byte is
  // newest, i = 0) on a shift and compares it with pattern byte (length - 1 - i).
  // ---------------------------------------------------------------------
  llmf_pkg::cell_ctrl_t    cell_ctrl;
  logic [BYTE_W-1:0]       cell_q   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]  cell_hit;

  assign cell_ctrl.shift = in_fire && !is_newline;
  assign cell_ctrl.fold  = !case_sens_q;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [BYTE_W-1:0] data_in;
    logic [LEN_W-1:0]  pat_idx;
    logic              active;

    if (i == 0) begin : g_head
      assign data_in = in_item_i.text_byte;
    end else begin : g_body
      assign data_in = cell_q[i-1];
    end

    assign active  = (len_q > LEN_W'(i));
    assign pat_idx = len_q - LEN_W'(i + 1);

    llmf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .data_i     (data_in),
      .pat_byte_i (pat_all[pat_idx[3:0]*BYTE_W +: BYTE_W]),
      .active_i   (active),
      .data_o     (cell_q[i]),
      .hit_o      (cell_hit[i])
    );
  end

  // ---------------------------------------------------------------------
  // Match qualification: a searchable column, a legal length, enough bytes
  // on this line, and no overlap with the previous match.
  // ---------------------------------------------------------------------
  logic                   len_ok;
  logic                   col_sat;
  logic [COLUMN_BITS:0]   col_p1;
  logic [COLUMN_BITS:0]   len_ext;
  logic [COLUMN_BITS-1:0] start_col;
  logic                   match;

  assign len_ok    = (len_q != '0) && (len_q <= LEN_W'(MAX_PATTERN));
  assign col_sat   = (eff_col == {COLUMN_BITS{1'b1}});
  assign col_p1    = {1'b0, eff_col} + (COLUMN_BITS+1)'(1);
  assign len_ext   = (COLUMN_BITS+1)'(len_q);
  assign start_col = COLUMN_BITS'(col_p1 - len_ext);

  assign match = in_fire && !is_newline && !col_sat && len_ok &&
                 (col_p1 >= len_ext) && (start_col >= eff_resume) && (&cell_hit);

  // Saturate the start column into the 16-bit result field.
  logic [llmf_pkg::COLOUT_W-1:0] col_out;
  if (COLUMN_BITS > llmf_pkg::COLOUT_W) begin : g_col_sat
    assign col_out = (|start_col[COLUMN_BITS-1:llmf_pkg::COLOUT_W]) ?
                     {llmf_pkg::COLOUT_W{1'b1}} : start_col[llmf_pkg::COLOUT_W-1:0];
  end else begin : g_col_ext
    assign col_out = llmf_pkg::COLOUT_W'(start_col);
  end

  // ---------------------------------------------------------------------
  // Counter updates.
  // ---------------------------------------------------------------------
  logic [llmf_pkg::HITS_W-1:0] hits_inc;
  assign hits_inc = (hits_q == {llmf_pkg::HITS_W{1'b1}}) ? hits_q :
                    hits_q + llmf_pkg::HITS_W'(1);

  always_comb begin
    col_d     = col_q;
    resume_d  = resume_q;
    line_d    = line_q;
    hits_d    = hits_q;
    has_hit_d = has_hit_q;
    if (in_fire) begin
      if (is_newline) begin
        // Advance the line, clear the per-line state.
        line_d    = (eff_line == {llmf_pkg::LINE_W{1'b1}}) ? eff_line :
                    eff_line + llmf_pkg::LINE_W'(1);
        col_d     = '0;
        resume_d  = '0;
        has_hit_d = 1'b0;
      end else begin
        line_d    = eff_line;
        col_d     = col_sat ? eff_col : col_p1[COLUMN_BITS-1:0];
        resume_d  = eff_resume;
        has_hit_d = eff_has_hit;
        if (match) begin
          resume_d  = col_p1[COLUMN_BITS-1:0];
          hits_d    = hits_inc;
          has_hit_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      resume_q  <= '0;
      line_q    <= llmf_pkg::LINE_W'(1);
      hits_q    <= '0;
      has_hit_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      resume_q  <= resume_d;
      line_q    <= line_d;
      hits_q    <= hits_d;
      has_hit_q <= has_hit_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result buffer.
  // ---------------------------------------------------------------------
  llmf_pkg::out_item_t res_item;
  assign res_item.line_number   = eff_line;
  assign res_item.match_column  = col_out;
  assign res_item.first_in_line = !eff_has_hit;
  assign res_item.total_hits    = hits_inc;

  llmf_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (match),
    .item_i      (res_item),
    .ready_o     (fifo_ready),
    .valid_o     (out_valid_o),
    .pop_ready_i (out_ready_i),
    .item_o      (out_item_o)
  );

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_no_match_on_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_newline) |-> !match)
    else $error("match reported on a newline byte");

  a_resume_after_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match |=> (resume_q == $past(col_p1[COLUMN_BITS-1:0])))
    else $error("resume column not set past the match");

  a_hits_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (hits_q >= $past(hits_q)))
    else $error("hit total went backwards");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line number reached zero");

  a_match_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match |-> fifo_ready)
    else $error("result pushed into a full buffer");

endmodule

`default_nettype wire
